// ===== hw/rtl/csrgba_pkg.sv =====
package csrgba_pkg;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_RGB = 2'd0;
   localparam mode_type MODE_HSB = 2'd1;
   localparam mode_type MODE_HSL = 2'd2;

   localparam int MAX_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_COLOR_MODE = 3'd0;
   localparam csr_index_type CSR_FIRST_MAX  = 3'd1;
   localparam csr_index_type CSR_SECOND_MAX = 3'd2;
   localparam csr_index_type CSR_THIRD_MAX  = 3'd3;
   localparam csr_index_type CSR_ALPHA_MAX  = 3'd4;

   localparam logic [MAX_BITS-1:0] MAX_RESET = 16'd255;

endpackage

// ===== hw/rtl/csrgba_div.sv =====
module csrgba_div #(
   parameter int INPUT_BITS    = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                             clock,
   input  logic                             advance,
   input  logic [INPUT_BITS-1:0]            value_in,
   input  logic [csrgba_pkg::MAX_BITS-1:0]  max_in,
   output logic [FRACTION_BITS:0]           quot_out
);
   import csrgba_pkg::*;

   localparam int F  = FRACTION_BITS;
   localparam int CW = (INPUT_BITS > MAX_BITS) ? INPUT_BITS : MAX_BITS;

   logic [MAX_BITS-1:0] div_m;
   logic                full_in;
   logic [MAX_BITS-1:0] rem_in;

   logic [MAX_BITS-1:0] rem_ff  [0:F];
   logic [F-1:0]        quo_ff  [0:F];
   logic                full_ff [0:F];

   // a zero full scale acts as one
   assign div_m   = (max_in == '0) ? MAX_BITS'(1) : max_in;
   assign full_in = CW'(value_in) >= CW'(div_m);
   assign rem_in  = full_in ? '0 : MAX_BITS'(CW'(value_in));

   always_ff @(posedge clock) begin
      if (advance) begin
         full_ff[0] <= full_in;
         rem_ff[0]  <= rem_in;
         quo_ff[0]  <= '0;
      end
   end

   // one quotient bit per stage
   for (genvar k = 1; k <= F; k++) begin : g_step
      logic [MAX_BITS:0]   stg_dbl;
      logic                stg_take;
      logic [MAX_BITS-1:0] stg_rem_in;
      logic [F-1:0]        stg_quo_in;

      assign stg_dbl    = {rem_ff[k-1], 1'b0};
      assign stg_take   = stg_dbl >= {1'b0, div_m};
      assign stg_rem_in = stg_take ? MAX_BITS'(stg_dbl - {1'b0, div_m}) : MAX_BITS'(stg_dbl);
      assign stg_quo_in = {quo_ff[k-1][F-2:0], stg_take};

      always_ff @(posedge clock) begin
         if (advance) begin
            full_ff[k] <= full_ff[k-1];
            rem_ff[k]  <= stg_rem_in;
            quo_ff[k]  <= stg_quo_in;
         end
      end
   end

   assign quot_out = full_ff[F] ? {1'b1, {F{1'b0}}} : {1'b0, quo_ff[F]};

endmodule

// ===== hw/rtl/csrgba_hsx.sv =====
module csrgba_hsx #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                      clock,
   input  logic                      advance,
   input  csrgba_pkg::mode_type      mode,
   input  logic [FRACTION_BITS:0]    h_q,
   input  logic [FRACTION_BITS:0]    s_q,
   input  logic [FRACTION_BITS:0]    v_q,
   input  logic [FRACTION_BITS:0]    a_q,
   output logic [7:0]                red_out,
   output logic [7:0]                green_out,
   output logic [7:0]                blue_out,
   output logic [7:0]                alpha_out
);
   import csrgba_pkg::*;

   localparam int F  = FRACTION_BITS;
   localparam int W  = F + 1;
   localparam int HW = F + 3;
   localparam int SW = F + 5;

   localparam logic [W-1:0] ONE_Q = {1'b1, {F{1'b0}}};
   localparam logic signed [SW-1:0] ONE_S   = SW'(longint'(1) << F);
   localparam logic signed [SW-1:0] TWO_S   = SW'(longint'(2) << F);
   localparam logic signed [SW-1:0] THREE_S = SW'(longint'(3) << F);
   localparam logic signed [SW-1:0] FOUR_S  = SW'(longint'(4) << F);
   localparam logic signed [SW-1:0] SIX_S   = SW'(longint'(6) << F);

   typedef enum logic [1:0] {HK_RAMP, HK_TOP, HK_FLOOR} hue_kind_type;
   typedef struct packed {
      hue_kind_type  kind;
      logic [W-1:0]  op;
   } hue_sel_type;

   function automatic hue_sel_type hue_select(input logic signed [SW-1:0] hue);
      logic signed [SW-1:0] hw;
      logic signed [SW-1:0] dn;
      hue_sel_type          sel;
      hw = hue;
      if (hw < 0) begin
         hw = hw + SIX_S;
      end else if (hw >= SIX_S) begin
         hw = hw - SIX_S;
      end
      dn = FOUR_S - hw;
      sel.kind = HK_FLOOR;
      sel.op   = '0;
      if (hw < ONE_S) begin
         sel.kind = HK_RAMP;
         sel.op   = hw[W-1:0];
      end else if (hw < THREE_S) begin
         sel.kind = HK_TOP;
      end else if (hw < FOUR_S) begin
         sel.kind = HK_RAMP;
         sel.op   = dn[W-1:0];
      end
      return sel;
   endfunction

   function automatic logic [7:0] to_byte(input logic [W-1:0] q);
      logic [W+7:0] p;
      p = {q, 8'b0} - {8'b0, q};
      return p[F +: 8];
   endfunction

   // stage 1: hue sector, saturation products, HSL value
   logic [HW-1:0]  h6;
   logic [F-1:0]   frac;
   logic [W-1:0]   frac_c;
   logic [2*W-1:0] sf_prod;
   logic [2*W-1:0] sc_prod;
   logic [W:0]     one_s;
   logic [2*W:0]   lo_prod;
   logic [2*W-1:0] ls_prod;
   logic [W+1:0]   hi_val;
   logic [W+1:0]   val_raw;
   logic [W-1:0]   val_in;

   logic [HW-1:0]  s1_h6_ff;
   logic [W-1:0]   s1_h_ff, s1_s_ff, s1_v_ff, s1_a_ff, s1_sf_ff, s1_sc_ff, s1_val_ff;

   assign h6      = ({2'b00, h_q} << 2) + ({2'b00, h_q} << 1);
   assign frac    = h6[F-1:0];
   assign frac_c  = ONE_Q - {1'b0, frac};
   assign sf_prod = s_q * {1'b0, frac};
   assign sc_prod = s_q * frac_c;
   assign one_s   = {1'b0, ONE_Q} + {1'b0, s_q};
   assign lo_prod = one_s * {{(W+1){1'b0}}, v_q};
   assign ls_prod = v_q * s_q;
   assign hi_val  = {2'b00, v_q} + {2'b00, s_q} - {2'b00, ls_prod[F +: W]};
   assign val_raw = (v_q[F:F-1] == 2'b00) ? {1'b0, lo_prod[F +: W+1]} : hi_val;
   assign val_in  = (val_raw > {2'b00, ONE_Q}) ? ONE_Q : val_raw[W-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_h6_ff  <= h6;
         s1_h_ff   <= h_q;
         s1_s_ff   <= s_q;
         s1_v_ff   <= v_q;
         s1_a_ff   <= a_q;
         s1_sf_ff  <= sf_prod[F +: W];
         s1_sc_ff  <= sc_prod[F +: W];
         s1_val_ff <= val_in;
      end
   end

   // stage 2: HSB terms, HSL floor, span and hue classes
   logic [2*W-1:0] t1_prod, t2_prod, t3_prod;
   logic [W:0]     two_l;
   logic [W-1:0]   zest_in;
   logic [W-1:0]   span_in;
   logic signed [SW-1:0] hue_base;
   hue_sel_type    sel_in [0:2];

   logic [2:0]     s2_sector_ff;
   logic [W-1:0]   s2_t1_ff, s2_t2_ff, s2_t3_ff;
   logic [W-1:0]   s2_h_ff, s2_s_ff, s2_v_ff, s2_a_ff, s2_val_ff, s2_zest_ff, s2_span_ff;
   hue_sel_type    s2_sel_ff [0:2];

   assign t1_prod  = s1_v_ff * (ONE_Q - s1_s_ff);
   assign t2_prod  = s1_v_ff * (ONE_Q - s1_sf_ff);
   assign t3_prod  = s1_v_ff * (ONE_Q - s1_sc_ff);
   assign two_l    = {s1_v_ff, 1'b0};
   assign zest_in  = (two_l > {1'b0, s1_val_ff}) ? W'(two_l - {1'b0, s1_val_ff}) : '0;
   assign span_in  = (s1_val_ff > zest_in) ? (s1_val_ff - zest_in) : '0;
   assign hue_base = $signed({2'b00, s1_h6_ff});
   assign sel_in[0] = hue_select(hue_base + TWO_S);
   assign sel_in[1] = hue_select(hue_base);
   assign sel_in[2] = hue_select(hue_base - TWO_S);

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sector_ff <= s1_h6_ff[HW-1:F];
         s2_t1_ff     <= t1_prod[F +: W];
         s2_t2_ff     <= t2_prod[F +: W];
         s2_t3_ff     <= t3_prod[F +: W];
         s2_h_ff      <= s1_h_ff;
         s2_s_ff      <= s1_s_ff;
         s2_v_ff      <= s1_v_ff;
         s2_a_ff      <= s1_a_ff;
         s2_val_ff    <= s1_val_ff;
         s2_zest_ff   <= zest_in;
         s2_span_ff   <= span_in;
         for (int c = 0; c < 3; c++) begin
            s2_sel_ff[c] <= sel_in[c];
         end
      end
   end

   // stage 3: pick each channel, ramp products for HSL
   logic [W-1:0]   hsb_pick [0:2];
   logic [W-1:0]   rgb_pick [0:2];
   logic [2*W-1:0] ramp_prod [0:2];
   logic [W-1:0]   base_in [0:2];
   logic [W-1:0]   add_in  [0:2];

   logic [W-1:0]   s3_base_ff [0:2];
   logic [W-1:0]   s3_add_ff  [0:2];
   logic [W-1:0]   s3_a_ff;

   always_comb begin
      case (s2_sector_ff)
         3'd1: begin
            hsb_pick[0] = s2_t2_ff; hsb_pick[1] = s2_v_ff;  hsb_pick[2] = s2_t1_ff;
         end
         3'd2: begin
            hsb_pick[0] = s2_t1_ff; hsb_pick[1] = s2_v_ff;  hsb_pick[2] = s2_t3_ff;
         end
         3'd3: begin
            hsb_pick[0] = s2_t1_ff; hsb_pick[1] = s2_t2_ff; hsb_pick[2] = s2_v_ff;
         end
         3'd4: begin
            hsb_pick[0] = s2_t3_ff; hsb_pick[1] = s2_t1_ff; hsb_pick[2] = s2_v_ff;
         end
         3'd5: begin
            hsb_pick[0] = s2_v_ff;  hsb_pick[1] = s2_t1_ff; hsb_pick[2] = s2_t2_ff;
         end
         default: begin
            // red sector, also hue of exactly one
            hsb_pick[0] = s2_v_ff;  hsb_pick[1] = s2_t3_ff; hsb_pick[2] = s2_t1_ff;
         end
      endcase
   end

   assign rgb_pick[0] = s2_h_ff;
   assign rgb_pick[1] = s2_s_ff;
   assign rgb_pick[2] = s2_v_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ramp_prod[c] = s2_span_ff * s2_sel_ff[c].op;
         add_in[c]    = '0;
         if (mode != MODE_HSB && mode != MODE_HSL) begin
            base_in[c] = rgb_pick[c];
         end else if (s2_s_ff == '0) begin
            base_in[c] = s2_v_ff;
         end else if (mode == MODE_HSB) begin
            base_in[c] = hsb_pick[c];
         end else begin
            case (s2_sel_ff[c].kind)
               HK_RAMP: begin
                  base_in[c] = s2_zest_ff;
                  add_in[c]  = ramp_prod[c][F +: W];
               end
               HK_TOP:  base_in[c] = s2_val_ff;
               default: base_in[c] = s2_zest_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 3; c++) begin
            s3_base_ff[c] <= base_in[c];
            s3_add_ff[c]  <= add_in[c];
         end
         s3_a_ff <= s2_a_ff;
      end
   end

   // stage 4: finish the sum, scale to bytes
   logic [W:0]   sum_raw [0:2];
   logic [W-1:0] sum_q   [0:2];
   logic [7:0]   red_ff, green_ff, blue_ff, alpha_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_raw[c] = {1'b0, s3_base_ff[c]} + {1'b0, s3_add_ff[c]};
         sum_q[c]   = (sum_raw[c] > {1'b0, ONE_Q}) ? ONE_Q : sum_raw[c][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= to_byte(sum_q[0]);
         green_ff <= to_byte(sum_q[1]);
         blue_ff  <= to_byte(sum_q[2]);
         alpha_ff <= to_byte(s3_a_ff);
      end
   end

   assign red_out   = red_ff;
   assign green_out = green_ff;
   assign blue_out  = blue_ff;
   assign alpha_out = alpha_ff;

endmodule

// ===== hw/rtl/color_space_to_rgba_converter.sv =====
// Color-space to RGBA converter.
// Input channel (req_): four channel values, first to alpha. An item is taken
// at a clock edge with req_valid high and req_stall low.
// Result channel (rsp_): 8-bit red, green, blue and alpha, one item per input,
// delivered in order when rsp_valid is high and rsp_stall is low.
// Configuration (csr_): write color_mode (index 0) and the four full-scale
// registers (indexes 1 to 4) while no item is in flight; no read-back.
// Throughput: one item per clock while rsp_stall does not hold the pipeline. The
// path is a normalizing divider with one quotient bit per stage (FRACTION_BITS + 1
// stages) followed by four stages of color math ending in the output register.
// When rsp_stall is high with a result waiting, the whole pipeline holds and
// req_stall rises in the same cycle; bubbles in flight are kept as bubbles.
// Reset empties the pipeline, sets RGB mode and every full scale to 255.
module color_space_to_rgba_converter #(
   parameter int INPUT_BITS    = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [INPUT_BITS-1:0]                   req_first_value,
   input  logic [INPUT_BITS-1:0]                   req_second_value,
   input  logic [INPUT_BITS-1:0]                   req_third_value,
   input  logic [INPUT_BITS-1:0]                   req_alpha_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [7:0]                              rsp_red_out,
   output logic [7:0]                              rsp_green_out,
   output logic [7:0]                              rsp_blue_out,
   output logic [7:0]                              rsp_alpha_out,
   input  logic                                    csr_write_enable,
   input  csrgba_pkg::csr_index_type               csr_index,
   input  logic [csrgba_pkg::MAX_BITS-1:0]         csr_write_data
);
   import csrgba_pkg::*;

   localparam int LAT = FRACTION_BITS + 5;

   logic                advance;
   logic [LAT-1:0]      valid_ff;
   mode_type            color_mode_ff;
   logic [MAX_BITS-1:0] first_max_ff, second_max_ff, third_max_ff, alpha_max_ff;
   logic [FRACTION_BITS:0] h_q, s_q, v_q, a_q;

   // hold everything while a result waits on a stalled receiver
   assign advance   = !(valid_ff[LAT-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= MODE_RGB;
         first_max_ff  <= MAX_RESET;
         second_max_ff <= MAX_RESET;
         third_max_ff  <= MAX_RESET;
         alpha_max_ff  <= MAX_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COLOR_MODE: color_mode_ff <= csr_write_data[1:0];
            CSR_FIRST_MAX:  first_max_ff  <= csr_write_data;
            CSR_SECOND_MAX: second_max_ff <= csr_write_data;
            CSR_THIRD_MAX:  third_max_ff  <= csr_write_data;
            CSR_ALPHA_MAX:  alpha_max_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   csrgba_div #(.INPUT_BITS(INPUT_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div_first (
      .clock(clock), .advance(advance), .value_in(req_first_value),
      .max_in(first_max_ff), .quot_out(h_q)
   );

   csrgba_div #(.INPUT_BITS(INPUT_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div_second (
      .clock(clock), .advance(advance), .value_in(req_second_value),
      .max_in(second_max_ff), .quot_out(s_q)
   );

   csrgba_div #(.INPUT_BITS(INPUT_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div_third (
      .clock(clock), .advance(advance), .value_in(req_third_value),
      .max_in(third_max_ff), .quot_out(v_q)
   );

   csrgba_div #(.INPUT_BITS(INPUT_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div_alpha (
      .clock(clock), .advance(advance), .value_in(req_alpha_value),
      .max_in(alpha_max_ff), .quot_out(a_q)
   );

   csrgba_hsx #(.FRACTION_BITS(FRACTION_BITS)) u_hsx (
      .clock(clock), .advance(advance), .mode(color_mode_ff),
      .h_q(h_q), .s_q(s_q), .v_q(v_q), .a_q(a_q),
      .red_out(rsp_red_out), .green_out(rsp_green_out),
      .blue_out(rsp_blue_out), .alpha_out(rsp_alpha_out)
   );

   // items in flight change only by accepts and deliveries
   a_item_count: assert property (@(posedge clock) disable iff (reset)
      advance |=> $countones(valid_ff) ==
         $countones($past(valid_ff)) + int'($past(req_valid)) - int'($past(valid_ff[LAT-1])))
      else $error("item count in pipeline broken");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline moved while stalled");

endmodule
